[hw/rtl/ovp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ovp_pkg;

  localparam int DefMaxTracks = 16;
  localparam int DefMaxPoints = 64;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOVEL = 2'd1;
  localparam logic [1:0] ST_BADID = 2'd2;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_STEP   = 2'd1;
  localparam logic [1:0] REG_POINTS = 2'd2;

  localparam logic signed [23:0] HalfPiQ20 = 24'sd1647099;

  typedef struct packed {
    logic [3:0]         obstacle_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [47:0]        stamp;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         track_id;
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [15:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [47:0]        pred_time;
    logic               last_point;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic signed [23:0] atan_q20(input logic [4:0] i);
    case (i)
      5'd0:  atan_q20 = 24'sd823550;
      5'd1:  atan_q20 = 24'sd486170;
      5'd2:  atan_q20 = 24'sd256879;
      5'd3:  atan_q20 = 24'sd130396;
      5'd4:  atan_q20 = 24'sd65451;
      5'd5:  atan_q20 = 24'sd32757;
      5'd6:  atan_q20 = 24'sd16383;
      5'd7:  atan_q20 = 24'sd8192;
      5'd8:  atan_q20 = 24'sd4096;
      5'd9:  atan_q20 = 24'sd2048;
      5'd10: atan_q20 = 24'sd1024;
      5'd11: atan_q20 = 24'sd512;
      5'd12: atan_q20 = 24'sd256;
      5'd13: atan_q20 = 24'sd128;
      5'd14: atan_q20 = 24'sd64;
      5'd15: atan_q20 = 24'sd32;
      5'd16: atan_q20 = 24'sd16;
      5'd17: atan_q20 = 24'sd8;
      5'd18: atan_q20 = 24'sd4;
      5'd19: atan_q20 = 24'sd2;
      default: atan_q20 = 24'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ovp_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle. 48-bit dividend/divisor.
module ovp_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [47:0] divisor,
  output logic             done,
  output logic [47:0]      quotient
);
  logic [47:0] rem;
  logic [47:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [47:0] dvs;
  logic [48:0] trial;

  // partial remainder stays below the divisor, so 48 bits hold it
  assign trial = {rem, quo[47]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          quo <= {quo[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], quo[47]};
          quo <= {quo[46:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/obstacle_velocity_predictor_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Constant-velocity obstacle predictor.
// Input channel (in_valid/in_stall/in_data): one position request per
// sample. Output channel (out_valid/out_stall/out_data): points_per_horizon
// results, 1..MAX_POINTS, per sample (bad index: one); last_point on final.
// Config port (cfg_we/cfg_index/cfg_data): write only while idle.
// Per sample: a table read, then two passes on the shared serial divider
// (velocity x, then y), each a start state and a wait for done, a quadrant
// fold and the CORDIC heading. Each point then runs S_PXL, S_PXH, S_PYL,
// S_PYH and S_EMIT: the one shared 32x32 multiplier forms the low and high
// partial products for x, then for y, and the result register is loaded.
// The next sample is taken only after the last point of the previous one
// is loaded into the result register. A bad index gives a single result,
// after which the input is free again.
// in_stall is high whenever a sample is in work. A stalled result holds in
// the output register; the sequencer waits before loading the next point,
// so a long out_stall backs up to the input.
// Reset clears the seen flags, sets the config registers to their defaults
// and idles the sequencer; the stored last positions stay undefined until
// written.
module obstacle_velocity_predictor_core
  import ovp_pkg::*;
#(
  parameter int MAX_TRACKS = DefMaxTracks,
  parameter int MAX_POINTS = DefMaxPoints
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ovp_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ovp_pkg::out_item_t        out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOOK = 4'd1, S_DIVX = 4'd2,
    S_WX = 4'd3, S_DIVY = 4'd4, S_WY = 4'd5, S_FOLD = 4'd6, S_CORD = 4'd7,
    S_PXL = 4'd8, S_PXH = 4'd9, S_PYL = 4'd10, S_PYH = 4'd11,
    S_EMIT = 4'd12, S_BAD = 4'd13;

  logic [4:0]  obstacle_count;
  logic [31:0] step_time;
  logic [6:0]  points_per_horizon;

  logic [31:0] last_x [MAX_TRACKS];
  logic [31:0] last_y [MAX_TRACKS];
  logic [47:0] last_time [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] seen;
  logic [31:0] rd_x, rd_y;
  logic [47:0] rd_t;
  logic        rd_seen;

  logic [3:0]  state;
  in_item_t    smp;
  logic [TW-1:0] tix;
  logic signed [31:0] vx, vy;
  logic [1:0]  st;
  logic [47:0] dt;
  logic        dneg;
  logic [6:0]  npts, j;
  logic [47:0] t;
  logic [4:0]  ci;
  logic signed [49:0] cx, cy;
  logic signed [23:0] cz;
  logic signed [15:0] hd;
  logic [64:0] acc;
  logic [63:0] prod;
  logic [31:0] ma, mb;
  logic signed [31:0] px_res;

  // divider
  logic        dv_start, dv_done;
  logic [47:0] dv_num, dv_q;
  logic signed [32:0] dpos;
  logic [31:0] dmag;
  logic signed [31:0] vq;

  logic signed [49:0] sx, sy;
  logic [33:0] offc;
  logic signed [31:0] psel;
  logic        pneg;
  logic signed [34:0] pext, psum;
  logic [31:0] vxmag, vymag;
  logic [48:0] ptime;
  logic signed [24:0] hround;
  logic        emit_go;
  out_item_t   out_next;

  ovp_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_num),
    .divisor(dt), .done(dv_done), .quotient(dv_q)
  );

  assign dt = smp.stamp - rd_t;
  assign dpos = (state == S_DIVX) ?
      ($signed({smp.pos_x[31], smp.pos_x}) - $signed({rd_x[31], rd_x})) :
      ($signed({smp.pos_y[31], smp.pos_y}) - $signed({rd_y[31], rd_y}));
  assign dmag = dpos[32] ? 32'(-dpos) : dpos[31:0];
  assign dv_num = {dmag, 16'd0};
  assign dv_start = (state == S_DIVX) || (state == S_DIVY);

  // saturate quotient with sign
  function automatic logic signed [31:0] vsat(input logic [47:0] q,
                                              input logic neg);
    if (neg) begin
      if (q > 48'h8000_0000) vsat = 32'sh8000_0000;
      else vsat = 32'(-$signed({1'b0, q}));
    end else begin
      if (q > 48'h7FFF_FFFF) vsat = 32'sh7FFF_FFFF;
      else vsat = q[31:0];
    end
  endfunction

  assign vq = vsat(dv_q, dneg);

  // shared multiplier: low then high half of t, x pass then y pass
  assign vxmag = vx[31] ? 32'(-vx) : vx;
  assign vymag = vy[31] ? 32'(-vy) : vy;
  assign ma = (state == S_PXL || state == S_PXH) ? vxmag : vymag;
  assign mb = (state == S_PXL || state == S_PYL) ? t[31:0] : {16'd0, t[47:32]};
  assign prod = 64'(ma) * 64'(mb);

  // cordic step
  assign sx = cx >>> ci;
  assign sy = cy >>> ci;

  // offset clamp and position add; x while in PYL, y while in EMIT
  assign offc = (acc > 65'h2_0000_0000) ? 34'h2_0000_0000 : acc[33:0];
  assign psel = (state == S_PYL) ? smp.pos_x : smp.pos_y;
  assign pneg = (state == S_PYL) ? vx[31] : vy[31];
  assign pext = {{3{psel[31]}}, psel};
  assign psum = pneg ? (pext - $signed({1'b0, offc}))
                     : (pext + $signed({1'b0, offc}));
  function automatic logic signed [31:0] psat(input logic signed [34:0] v);
    if (v > 35'sh7FFF_FFFF) psat = 32'sh7FFF_FFFF;
    else if (v < -35'sh8000_0000) psat = 32'sh8000_0000;
    else psat = v[31:0];
  endfunction

  assign ptime = {1'b0, smp.stamp} + {1'b0, t};

  assign hround = ($signed({cz[23], cz}) + 25'sd64) >>> 7;

  assign in_stall = (state != S_IDLE);

  // result register loads only when empty or being taken
  assign emit_go = ((state == S_EMIT) || (state == S_BAD)) &&
                   (!out_valid || !out_stall);

  always_comb begin
    out_next = '0;
    out_next.track_id = smp.obstacle_id;
    if (state == S_EMIT) begin
      out_next.pred_x = px_res;
      out_next.pred_y = psat(psum);
      out_next.heading = hd;
      out_next.vel_x = vx;
      out_next.vel_y = vy;
      out_next.pred_time = ptime[48] ? 48'hFFFF_FFFF_FFFF : ptime[47:0];
      out_next.last_point = (j + 7'd1 == npts);
      out_next.status = st;
    end else begin
      out_next.last_point = 1'b1;
      out_next.status = ST_BADID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) out_data <= out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_count     <= 5'd1;
      step_time          <= 32'd6554;
      points_per_horizon <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT:  obstacle_count <= cfg_data[4:0];
        REG_STEP:   step_time <= cfg_data;
        REG_POINTS: points_per_horizon <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOK) begin
      rd_x <= last_x[tix];
      rd_y <= last_y[tix];
      rd_t <= last_time[tix];
    end
    if (state == S_WY && dv_done) begin
      last_x[tix] <= smp.pos_x;
      last_y[tix] <= smp.pos_y;
      last_time[tix] <= smp.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      seen <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp <= in_data;
            tix <= TW'(in_data.obstacle_id);
            if ({1'b0, in_data.obstacle_id} >= obstacle_count ||
                32'(in_data.obstacle_id) >= 32'(MAX_TRACKS)) begin
              state <= S_BAD;
            end else begin
              rd_seen <= seen[TW'(in_data.obstacle_id)];
              state <= S_LOOK;
            end
            if (points_per_horizon == 7'd0) npts <= 7'd1;
            else if (32'(points_per_horizon) > 32'(MAX_POINTS))
              npts <= 7'(MAX_POINTS);
            else npts <= points_per_horizon;
          end
        end
        S_LOOK: state <= S_DIVX;
        S_DIVX: begin
          dneg <= dpos[32];
          state <= S_WX;
        end
        S_WX: if (dv_done) begin
          vx <= vq;
          state <= S_DIVY;
        end
        S_DIVY: begin
          dneg <= dpos[32];
          state <= S_WY;
        end
        S_WY: if (dv_done) begin
          seen[tix] <= 1'b1;
          if (rd_seen && smp.stamp > rd_t) begin
            vy <= vq;
            st <= ST_OK;
          end else begin
            vx <= '0;
            vy <= '0;
            st <= ST_NOVEL;
          end
          state <= S_FOLD;
        end
        // left half plane turned by +-pi/2 before vectoring
        S_FOLD: begin
          if (vx[31]) begin
            if (!vy[31]) begin
              cx <= {{2{vy[31]}}, vy, 16'd0};
              cy <= -{{2{vx[31]}}, vx, 16'd0};
              cz <= HalfPiQ20;
            end else begin
              cx <= -{{2{vy[31]}}, vy, 16'd0};
              cy <= {{2{vx[31]}}, vx, 16'd0};
              cz <= -HalfPiQ20;
            end
          end else begin
            cx <= {{2{vx[31]}}, vx, 16'd0};
            cy <= {{2{vy[31]}}, vy, 16'd0};
            cz <= '0;
          end
          ci <= 5'd0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (ci == 5'd20) begin
            if (vx == 32'sd0 && vy == 32'sd0) hd <= '0;
            else if (hround > 25'sd25736) hd <= 16'sd25736;
            else if (hround < -25'sd25736) hd <= -16'sd25736;
            else hd <= hround[15:0];
            j <= 7'd0;
            t <= '0;
            state <= S_PXL;
          end else begin
            if (!cy[49]) begin
              cx <= cx + sy;
              cy <= cy - sx;
              cz <= cz + atan_q20(ci);
            end else begin
              cx <= cx - sy;
              cy <= cy + sx;
              cz <= cz - atan_q20(ci);
            end
            ci <= ci + 5'd1;
          end
        end
        // offset = floor(|v| * t / 65536) from two partial products
        S_PXL: begin
          acc <= {17'd0, prod[63:16]};
          state <= S_PXH;
        end
        S_PXH: begin
          acc <= acc + {1'b0, prod[47:0], 16'd0};
          state <= S_PYL;
        end
        S_PYL: begin
          px_res <= psat(psum);
          acc <= {17'd0, prod[63:16]};
          state <= S_PYH;
        end
        S_PYH: begin
          acc <= acc + {1'b0, prod[47:0], 16'd0};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            if (j + 7'd1 == npts) state <= S_IDLE;
            else begin
              j <= j + 7'd1;
              t <= t + {16'd0, step_time};
              state <= S_PXL;
            end
          end
        end
        S_BAD: begin
          if (emit_go) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
